/* rtl/core/fm_chip_register_shadow_rmw_macros.svh */
// Assertion macros for the FM register shadow block.
// Used by the port checker; clock aclk and reset aresetn are assumed in scope.
`ifndef FM_CHIP_REGISTER_SHADOW_RMW_MACROS_SVH
`define FM_CHIP_REGISTER_SHADOW_RMW_MACROS_SVH

// Plain property, disabled while reset is held
`define FMCS_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("fmcs port check failed");

// Same-cycle implication
`define FMCS_ASSERT_IMP(label, ante, cons) `FMCS_ASSERT(label, (ante) |-> (cons))

// Next-cycle implication
`define FMCS_ASSERT_NXT(label, ante, cons) `FMCS_ASSERT(label, (ante) |=> (cons))

`endif

/* rtl/core/fmcs_pkg.sv */
// Shared types and codes of the FM register shadow block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package fmcs_pkg;

    // Stream widths
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    // Shadow RAM: two parts of 256 bytes
    localparam int SHADOW_DEPTH = 512;
    localparam int SHADOW_AW    = 9;

    // Request operations (s_tuser)
    localparam logic [1:0] OP_FIELD_WR = 2'd0;
    localparam logic [1:0] OP_FIELD_RD = 2'd1;
    localparam logic [1:0] OP_KEY      = 2'd2;
    localparam logic [1:0] OP_FREQ     = 2'd3;

    // Address modes
    localparam logic [1:0] MODE_GLOBAL = 2'd0;
    localparam logic [1:0] MODE_CHAN   = 2'd1;
    localparam logic [1:0] MODE_OPER   = 2'd2;

    // Result kinds (m_tuser)
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // Fixed chip registers
    localparam logic [7:0] KEY_ADDR      = 8'h28;
    localparam logic [7:0] FREQ_LO_BASE  = 8'hA0;
    localparam logic [7:0] FREQ_HI_OFFS  = 8'h04;

    // Classified command handed from front to back
    typedef enum logic [2:0] {
        CMD_WRITE,
        CMD_READ,
        CMD_KEY,
        CMD_FREQ,
        CMD_REJECT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        part;
        logic [7:0]  addr;   // register address (low byte address for FREQ)
        logic [7:0]  mask;   // field mask
        logic [7:0]  data;   // shifted field, key byte, or FREQ high byte
        logic [7:0]  data2;  // FREQ low byte
        logic [2:0]  shift;  // lowest set bit of mask
    } cmd_t;

    // Queue status seen by the front
    typedef struct packed {
        logic full;
        logic valid;
    } q_stat_t;

    // One result item
    typedef struct packed {
        logic [1:0] kind;
        logic       part;
        logic [7:0] bus_addr;
        logic [7:0] bus_data;
        logic [7:0] read_value;
        logic       last;
    } res_t;

endpackage

`default_nettype wire

/* rtl/core/fmcs_front.sv */
// Front end: accepts requests and classifies them into commands.
// Depends on fmcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmcs_front (
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [fmcs_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [fmcs_pkg::S_TUSER_W-1:0] s_tuser,
    input  wire fmcs_pkg::q_stat_t             q_stat,
    input  wire logic                          clear_busy,
    output logic                               push,
    output fmcs_pkg::cmd_t                     push_cmd
);
    import fmcs_pkg::*;

    logic [1:0]  op;
    logic [1:0]  addr_mode;
    logic [7:0]  reg_base;
    logic [2:0]  channel;
    logic [1:0]  oper;
    logic [7:0]  mask;
    logic [7:0]  value;
    logic [2:0]  octave;
    logic [10:0] fnum;

    logic [1:0]  ch_mod3;
    logic        ch_part;
    logic [2:0]  key_ch;
    logic [2:0]  shift;
    logic [7:0]  shifted;

    // Field unpacking
    assign op        = s_tuser[1:0];
    assign addr_mode = s_tdata[1:0];
    assign reg_base  = s_tdata[9:2];
    assign channel   = s_tdata[12:10];
    assign oper      = s_tdata[14:13];
    assign mask      = s_tdata[22:15];
    assign value     = s_tdata[30:23];
    assign octave    = s_tdata[33:31];
    assign fnum      = s_tdata[44:34];

    // Handshake: hold off during the RAM sweep or when the queue is full
    assign s_tready = !q_stat.full && !clear_busy;
    assign push     = s_tvalid && s_tready;

    // Channel within its part
    always_comb begin
        case (channel) inside
            3'd0, 3'd3, 3'd6: ch_mod3 = 2'd0;
            3'd1, 3'd4, 3'd7: ch_mod3 = 2'd1;
            default:          ch_mod3 = 2'd2;
        endcase
    end

    assign ch_part = (channel >= 3'd3);
    // Key register skips slot 3: channels 3 and up move one place up
    assign key_ch  = ch_part ? channel + 3'd1 : channel;

    // Lowest set bit of the mask
    always_comb begin
        shift = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (mask[3'(i)]) begin
                shift = 3'(i);
            end
        end
    end

    assign shifted = value << shift;

    // Classification
    always_comb begin
        push_cmd       = '0;
        push_cmd.mask  = mask;
        push_cmd.shift = shift;
        case (op)
            OP_KEY: begin
                push_cmd.kind = CMD_KEY;
                push_cmd.part = 1'b0;
                push_cmd.addr = KEY_ADDR;
                push_cmd.data = {value[3:0], 1'b0, key_ch};
            end
            OP_FREQ: begin
                push_cmd.kind  = CMD_FREQ;
                push_cmd.part  = ch_part;
                push_cmd.addr  = FREQ_LO_BASE + {6'd0, ch_mod3};
                push_cmd.data  = {2'b00, octave, fnum[10:8]};
                push_cmd.data2 = fnum[7:0];
            end
            default: begin
                if (mask == 8'd0) begin
                    push_cmd.kind = CMD_REJECT;
                end else begin
                    push_cmd.kind = (op == OP_FIELD_RD) ? CMD_READ : CMD_WRITE;
                    push_cmd.data = shifted & mask;
                    case (addr_mode)
                        MODE_CHAN: begin
                            push_cmd.part = ch_part;
                            push_cmd.addr = reg_base + {6'd0, ch_mod3};
                        end
                        MODE_OPER: begin
                            push_cmd.part = ch_part;
                            push_cmd.addr = reg_base + {4'd0, oper, 2'b00}
                                          + {6'd0, ch_mod3};
                        end
                        default: begin
                            push_cmd.part = 1'b0;
                            push_cmd.addr = reg_base;
                        end
                    endcase
                end
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/fmcs_cmd_queue.sv */
// Two-entry command queue between front and back.
// Depends on fmcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmcs_cmd_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire fmcs_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output fmcs_pkg::q_stat_t   q_stat,
    output fmcs_pkg::cmd_t      head_cmd
);
    import fmcs_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.valid = (count_reg != 2'd0);
    assign head_cmd     = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/fmcs_back.sv */
// Back end: shadow RAM, read-modify-write sequencer and result register.
// Depends on fmcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmcs_back #(
    parameter int unsigned FIRST_ADDR = 33
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire fmcs_pkg::q_stat_t q_stat,
    input  wire fmcs_pkg::cmd_t    head_cmd,
    output logic                   pop,
    output logic                   clear_busy,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output fmcs_pkg::res_t         out_res
);
    import fmcs_pkg::*;

    localparam logic [7:0] FirstAddr = 8'(FIRST_ADDR);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW,
        ST_FREQ2
    } state_t;

    state_t                state_reg, state_next;
    cmd_t                  cur_reg, cur_next;
    logic [SHADOW_AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic                  out_valid_reg, out_valid_next;
    res_t                  out_reg, out_next;

    logic [7:0]            shadow_mem [SHADOW_DEPTH];
    logic [7:0]            rd_data_reg;
    logic                  mem_we;
    logic [SHADOW_AW-1:0]  mem_waddr;
    logic [7:0]            mem_wdata;
    logic                  mem_re;
    logic [SHADOW_AW-1:0]  mem_raddr;

    logic                  out_free;
    logic [7:0]            freq_hi_addr;
    logic [7:0]            merged;

    function automatic logic [SHADOW_AW-1:0] shadow_idx(input logic part,
                                                        input logic [7:0] addr);
        logic [7:0] offs;
        offs = addr - FirstAddr;
        return {part, offs};
    endfunction

    assign out_free     = !out_valid_reg || out_ready;
    assign clear_busy   = (state_reg == ST_CLEAR);
    assign out_valid    = out_valid_reg;
    assign out_res      = out_reg;
    assign freq_hi_addr = head_cmd.addr + FREQ_HI_OFFS;
    assign merged       = (rd_data_reg & ~cur_reg.mask) | cur_reg.data;

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;

        case (state_reg)
            ST_CLEAR: begin
                // Sweep the shadow to zero after reset
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + SHADOW_AW'(1);
                if (clr_cnt_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_stat.valid && out_free) begin
                    pop = 1'b1;
                    case (head_cmd.kind)
                        CMD_KEY: begin
                            out_valid_next = 1'b1;
                            out_next = '{kind: KIND_WRITE, part: 1'b0,
                                         bus_addr: head_cmd.addr,
                                         bus_data: head_cmd.data,
                                         read_value: 8'd0, last: 1'b1};
                        end
                        CMD_REJECT: begin
                            out_valid_next = 1'b1;
                            out_next = '{kind: KIND_REJECT, part: 1'b0,
                                         bus_addr: 8'd0, bus_data: 8'd0,
                                         read_value: 8'd0, last: 1'b1};
                        end
                        CMD_FREQ: begin
                            // Block / high bits first, cached
                            mem_we         = 1'b1;
                            mem_waddr      = shadow_idx(head_cmd.part, freq_hi_addr);
                            mem_wdata      = head_cmd.data;
                            out_valid_next = 1'b1;
                            out_next = '{kind: KIND_WRITE, part: head_cmd.part,
                                         bus_addr: freq_hi_addr,
                                         bus_data: head_cmd.data,
                                         read_value: 8'd0, last: 1'b0};
                            cur_next       = head_cmd;
                            state_next     = ST_FREQ2;
                        end
                        default: begin
                            // Field access: fetch the shadow byte
                            mem_re     = 1'b1;
                            mem_raddr  = shadow_idx(head_cmd.part, head_cmd.addr);
                            cur_next   = head_cmd;
                            state_next = ST_RMW;
                        end
                    endcase
                end
            end
            ST_RMW: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    if (cur_reg.kind == CMD_READ) begin
                        out_next = '{kind: KIND_READ, part: cur_reg.part,
                                     bus_addr: cur_reg.addr, bus_data: 8'd0,
                                     read_value: (rd_data_reg & cur_reg.mask)
                                                 >> cur_reg.shift,
                                     last: 1'b1};
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = shadow_idx(cur_reg.part, cur_reg.addr);
                        mem_wdata = merged;
                        out_next = '{kind: KIND_WRITE, part: cur_reg.part,
                                     bus_addr: cur_reg.addr, bus_data: merged,
                                     read_value: 8'd0, last: 1'b1};
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_FREQ2: begin
                // Low byte of the frequency number
                if (out_free) begin
                    mem_we         = 1'b1;
                    mem_waddr      = shadow_idx(cur_reg.part, cur_reg.addr);
                    mem_wdata      = cur_reg.data2;
                    out_valid_next = 1'b1;
                    out_next = '{kind: KIND_WRITE, part: cur_reg.part,
                                 bus_addr: cur_reg.addr, bus_data: cur_reg.data2,
                                 read_value: 8'd0, last: 1'b1};
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and result register
    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        out_reg <= out_next;
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Shadow RAM, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            shadow_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= shadow_mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/fm_chip_register_shadow_rmw.sv */
// Top level of the FM register shadow: front, command queue and back.
// Field read/write: the back reads the shadow RAM, then merges and writes the byte.
// Frequency op: two results, high byte then low byte; key on/off and reject: one result.
// A field access or frequency op holds the back through both steps, the registered
// shadow read ahead of the merge and write, or the two writes of a frequency op.
// Reset: synchronous; the shadow RAM is then swept to zero, s_tready low.
`timescale 1ns / 1ps
`default_nettype none

module fm_chip_register_shadow_rmw #(
    parameter int unsigned FIRST_ADDR = 33
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // addr_mode[1:0] reg_base[9:2] channel[12:10] oper[14:13] mask[22:15]
    // value[30:23] octave[33:31] fnum[44:34], zeros above
    input  wire logic [fmcs_pkg::S_TDATA_W-1:0] s_tdata,
    // op[1:0]
    input  wire logic [fmcs_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // part[0] bus_addr[8:1] bus_data[16:9] read_value[24:17], zeros above
    output logic [fmcs_pkg::M_TDATA_W-1:0]      m_tdata,
    // kind[1:0]
    output logic [fmcs_pkg::M_TUSER_W-1:0]      m_tuser,
    output logic                                m_tlast
);
    import fmcs_pkg::*;

    q_stat_t q_stat;
    cmd_t    push_cmd;
    cmd_t    head_cmd;
    logic    push;
    logic    pop;
    logic    clear_busy;
    res_t    out_res;

    fmcs_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_stat     (q_stat),
        .clear_busy (clear_busy),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    fmcs_cmd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .q_stat   (q_stat),
        .head_cmd (head_cmd)
    );

    fmcs_back #(
        .FIRST_ADDR (FIRST_ADDR)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_stat     (q_stat),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .clear_busy (clear_busy),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (out_res)
    );

    // Result packing
    assign m_tdata = {7'd0, out_res.read_value, out_res.bus_data,
                      out_res.bus_addr, out_res.part};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

`default_nettype wire

/* rtl/core/fmcs_checker.sv */
// Port-level checker for the FM register shadow, bound to the top level.
// Depends on fmcs_pkg and the block's assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "fm_chip_register_shadow_rmw_macros.svh"

module fmcs_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [fmcs_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic [fmcs_pkg::S_TUSER_W-1:0] s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [fmcs_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [fmcs_pkg::M_TUSER_W-1:0] m_tuser,
    input wire logic                           m_tlast
);
    import fmcs_pkg::*;

    // A stalled result holds
    `FMCS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // Leaving reset: RAM sweep blocks requests, nothing to deliver
    `FMCS_ASSERT_IMP(a_reset_sweep, $rose(aresetn), !s_tready && !m_tvalid)

    // Rejects carry nothing but the last flag
    `FMCS_ASSERT_IMP(a_reject_empty, m_tvalid && m_tuser == KIND_REJECT, m_tlast && m_tdata == '0)

    // Only the frequency high-byte write is not last
    `FMCS_ASSERT_IMP(a_first_freq, m_tvalid && !m_tlast, m_tuser == KIND_WRITE && m_tdata[8:5] == 4'hA)

    // The low-byte write follows at once
    `FMCS_ASSERT_NXT(a_freq_pair, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tlast)

endmodule

bind fm_chip_register_shadow_rmw fmcs_checker u_fmcs_checker (.*);

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the FM register shadow block (fm_chip_register_shadow_rmw).
// Predicts every result from its own shadow copy of both register parts; depends on fmcs_pkg.
`timescale 1ns / 1ps

module testbench;
    import fmcs_pkg::*;

    localparam int unsigned FIRST_ADDR = 33;
    localparam int HOLD_LEN = 150;
    localparam int DRAIN_LIMIT = 5000;
    localparam int MAX_PRINTS = 40;

    // Request fields as packed into s_tdata, addr_mode in the lowest bits
    typedef struct packed {
        logic [10:0] fnum;
        logic [2:0]  octave;
        logic [7:0]  value;
        logic [7:0]  mask;
        logic [1:0]  oper;
        logic [2:0]  channel;
        logic [7:0]  reg_base;
        logic [1:0]  addr_mode;
    } fm_req_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    // Predictor state and expected results
    logic [7:0] shadow_copy [0:511];
    res_t       pending_results [$];
    int         mismatch_count = 0;

    // Idle rates (percent) and receiver hold-off requests
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;

    fm_chip_register_shadow_rmw #(
        .FIRST_ADDR(FIRST_ADDR)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #2 aclk = ~aclk;

    // Run limit, far above the slowest legal run
    initial begin
        #2000000;
        $display("testbench: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // ---------------------------------------------------------------
    // Shadow predictor
    // ---------------------------------------------------------------
    function automatic logic [8:0] shadow_index(input logic part, input logic [7:0] addr);
        logic [7:0] offs;
        offs = addr - 8'(FIRST_ADDR);
        return {part, offs};
    endfunction

    function automatic void push_result(input logic [1:0] kind, input logic part,
                                        input logic [7:0] addr, input logic [7:0] data,
                                        input logic [7:0] rd, input logic last);
        res_t r;
        r = '{kind: kind, part: part, bus_addr: addr, bus_data: data,
              read_value: rd, last: last};
        pending_results.push_back(r);
    endfunction

    // Cached bus write: update the shadow and emit the write
    function automatic void store_and_push(input logic part, input logic [7:0] addr,
                                           input logic [7:0] data, input logic last);
        shadow_copy[shadow_index(part, addr)] = data;
        push_result(KIND_WRITE, part, addr, data, 8'h00, last);
    endfunction

    function automatic void predict_request(input logic [1:0] op, input fm_req_t r);
        logic       part;
        logic [1:0] ch_mod;
        logic [2:0] key_ch;
        logic [7:0] addr;
        logic [7:0] fmask;
        logic [7:0] cur;
        logic [7:0] field;
        int         shift;
        ch_mod = 2'(r.channel % 3);
        part = (r.channel >= 3);
        if (op == OP_KEY) begin
            // channels 3 and up skip one slot; 7 wraps to 0
            key_ch = (r.channel >= 3) ? r.channel + 3'd1 : r.channel;
            push_result(KIND_WRITE, 1'b0, KEY_ADDR, {r.value[3:0], 1'b0, key_ch}, 8'h00, 1'b1);
        end else if (op == OP_FREQ) begin
            addr = FREQ_LO_BASE + {6'd0, ch_mod};
            store_and_push(part, addr + FREQ_HI_OFFS, {2'b00, r.octave, r.fnum[10:8]}, 1'b0);
            store_and_push(part, addr, r.fnum[7:0], 1'b1);
        end else if (r.mask == 8'h00) begin
            push_result(KIND_REJECT, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1);
        end else begin
            case (r.addr_mode)
                MODE_CHAN: addr = r.reg_base + {6'd0, ch_mod};
                MODE_OPER: addr = r.reg_base + {4'd0, r.oper, 2'b00} + {6'd0, ch_mod};
                default: begin
                    // global, and the unused mode 3
                    addr = r.reg_base;
                    part = 1'b0;
                end
            endcase
            fmask = r.mask;
            shift = 0;
            while (!fmask[0] && shift < 7) begin
                fmask = fmask >> 1;
                shift++;
            end
            cur = shadow_copy[shadow_index(part, addr)];
            if (op == OP_FIELD_RD) begin
                field = (cur & r.mask) >> shift;
                push_result(KIND_READ, part, addr, 8'h00, field, 1'b1);
            end else begin
                field = (r.value & fmask) << shift;
                store_and_push(part, addr, (cur & ~r.mask) | field, 1'b1);
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------
    function automatic fm_req_t pack_fields(input logic [1:0] mode, input logic [7:0] base,
                                            input logic [2:0] ch, input logic [1:0] oper,
                                            input logic [7:0] mask, input logic [7:0] val,
                                            input logic [2:0] oct, input logic [10:0] fnum);
        fm_req_t r;
        r = '{fnum: fnum, octave: oct, value: val, mask: mask, oper: oper,
              channel: ch, reg_base: base, addr_mode: mode};
        return r;
    endfunction

    // Called at a rising edge; returns at the edge that accepts the request
    task automatic send_request(input logic [1:0] op, input fm_req_t r);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - $bits(fm_req_t)){1'b0}}, r};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        predict_request(op, r);
    endtask

    // Drop valid, then wait for every expected result
    task automatic wait_for_results();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            report_mismatch("results still missing", 0, pending_results.size());
            pending_results.delete();
        end
    endtask

    // ---------------------------------------------------------------
    // Result side: random ready with optional long hold-off
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{kind: m_tuser, part: m_tdata[0], bus_addr: m_tdata[8:1],
                    bus_data: m_tdata[16:9], read_value: m_tdata[24:17], last: m_tlast};
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", got, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
                if (got.part !== want.part) report_mismatch("part", got.part, want.part);
                if (got.bus_addr !== want.bus_addr)
                    report_mismatch("bus_addr", got.bus_addr, want.bus_addr);
                if (got.bus_data !== want.bus_data)
                    report_mismatch("bus_data", got.bus_data, want.bus_data);
                if (got.read_value !== want.read_value)
                    report_mismatch("read_value", got.read_value, want.read_value);
                if (got.last !== want.last) report_mismatch("last", got.last, want.last);
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Field extremes, zero masks, odd modes, address wrap, key and frequency ops
    task automatic test_directed();
        src_idle_pct = 10;
        sink_idle_pct = 10;
        send_request(OP_FIELD_WR, pack_fields(MODE_GLOBAL, 8'h22, 0, 0, 8'hFF, 8'hA5, 0, 0));
        send_request(OP_FIELD_RD, pack_fields(MODE_GLOBAL, 8'h22, 0, 0, 8'hF0, 8'h00, 0, 0));
        send_request(OP_FIELD_RD, pack_fields(MODE_GLOBAL, 8'h22, 0, 0, 8'h0F, 8'h00, 0, 0));
        // value wider than the field
        send_request(OP_FIELD_WR, pack_fields(MODE_GLOBAL, 8'h22, 0, 0, 8'h38, 8'hFF, 7, 11'h7FF));
        send_request(OP_FIELD_RD, pack_fields(MODE_GLOBAL, 8'h22, 0, 0, 8'h38, 8'hFF, 0, 0));
        // zero mask on write and read
        send_request(OP_FIELD_WR, pack_fields(MODE_CHAN, 8'h40, 5, 3, 8'h00, 8'hFF, 7, 11'h7FF));
        send_request(OP_FIELD_RD, pack_fields(MODE_OPER, 8'hFF, 7, 3, 8'h00, 8'hFF, 0, 0));
        // unused mode behaves as global
        send_request(OP_FIELD_WR, pack_fields(2'd3, 8'h30, 5, 2, 8'h80, 8'h01, 0, 0));
        // addresses below the first register wrap in the shadow
        send_request(OP_FIELD_WR, pack_fields(MODE_GLOBAL, 8'h00, 0, 0, 8'h01, 8'h01, 0, 0));
        send_request(OP_FIELD_RD, pack_fields(MODE_GLOBAL, 8'h00, 0, 0, 8'hFF, 8'h00, 0, 0));
        send_request(OP_FIELD_WR, pack_fields(MODE_GLOBAL, 8'h20, 0, 0, 8'hC0, 8'h03, 0, 0));
        // per-channel and per-operator, with address wrap past 0xFF
        send_request(OP_FIELD_WR, pack_fields(MODE_CHAN, 8'hB0, 4, 0, 8'h3F, 8'h2A, 0, 0));
        send_request(OP_FIELD_RD, pack_fields(MODE_CHAN, 8'hB0, 4, 0, 8'h3C, 8'h00, 0, 0));
        send_request(OP_FIELD_WR, pack_fields(MODE_OPER, 8'hFF, 7, 3, 8'h7F, 8'h55, 0, 0));
        send_request(OP_FIELD_RD, pack_fields(MODE_OPER, 8'hFF, 7, 3, 8'h7F, 8'h00, 0, 0));
        // key on/off, including channels 6 and 7
        send_request(OP_KEY, pack_fields(MODE_OPER, 8'hFF, 0, 3, 8'hFF, 8'hF0, 7, 0));
        send_request(OP_KEY, pack_fields(MODE_GLOBAL, 8'h00, 2, 0, 8'h00, 8'h0F, 0, 0));
        send_request(OP_KEY, pack_fields(MODE_GLOBAL, 8'h00, 3, 0, 8'h00, 8'h05, 0, 0));
        send_request(OP_KEY, pack_fields(MODE_GLOBAL, 8'h00, 5, 0, 8'h00, 8'hFA, 0, 0));
        send_request(OP_KEY, pack_fields(MODE_GLOBAL, 8'h00, 6, 0, 8'h00, 8'h03, 0, 0));
        send_request(OP_KEY, pack_fields(MODE_GLOBAL, 8'h00, 7, 0, 8'h00, 8'hFF, 0, 0));
        // frequency extremes, then read back the block byte
        send_request(OP_FREQ, pack_fields(MODE_GLOBAL, 8'h00, 0, 0, 8'h00, 8'h00, 7, 11'h7FF));
        send_request(OP_FREQ, pack_fields(MODE_OPER, 8'hFF, 5, 3, 8'hFF, 8'hFF, 0, 11'h000));
        send_request(OP_FREQ, pack_fields(MODE_GLOBAL, 8'h00, 6, 0, 8'h00, 8'h00, 3, 11'h2AA));
        send_request(OP_FIELD_RD, pack_fields(MODE_CHAN, 8'hA4, 0, 0, 8'hFF, 8'h00, 0, 0));
        wait_for_results();
    endtask

    function automatic fm_req_t random_fields();
        logic [7:0] base_pool [8];
        logic [7:0] base;
        logic [7:0] mask;
        base_pool = '{8'h21, 8'h22, 8'h30, 8'h40, 8'hA0, 8'hB0, 8'h00, 8'hFE};
        base = ($urandom_range(99) < 70) ? base_pool[3'($urandom_range(7))]
                                         : 8'($urandom_range(255));
        mask = ($urandom_range(99) < 6) ? 8'h00 : 8'($urandom_range(255));
        return pack_fields(2'($urandom_range(3)), base, 3'($urandom_range(7)),
                           2'($urandom_range(3)), mask, 8'($urandom_range(255)),
                           3'($urandom_range(7)), 11'($urandom_range(2047)));
    endfunction

    // Mixed traffic; many writes are followed by a read of the same field
    task automatic test_random_traffic(input int n_items, input int src_pct, input int sink_pct);
        fm_req_t r;
        int      pick;
        int      sent;
        logic [1:0] op;
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        sent = 0;
        while (sent < n_items) begin
            r = random_fields();
            pick = $urandom_range(99);
            op = (pick < 35) ? OP_FIELD_WR : (pick < 65) ? OP_FIELD_RD :
                 (pick < 80) ? OP_KEY : OP_FREQ;
            send_request(op, r);
            sent++;
            if (op == OP_FIELD_WR && $urandom_range(99) < 30) begin
                r.value = 8'($urandom_range(255));
                send_request(OP_FIELD_RD, r);
                sent++;
            end
        end
        wait_for_results();
    endtask

    // Receiver holds off while the sender keeps pushing, so the input stalls
    task automatic test_backpressure();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        hold_seq++;
        repeat (40) send_request(OP_FREQ, random_fields());
        wait_for_results();
    endtask

    initial begin
        shadow_copy = '{default: 8'h00};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_traffic(600, 24, 66);
        test_random_traffic(600, 66, 24);
        test_random_traffic(600, 0, 0);
        test_backpressure();

        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
